/* rtl/core/owpws_pkg.sv */
// Package for the one-wire pulse-width serializer.
// Holds the transaction payload types, op and CSR index codes and the tick width helper.
// No dependencies.
package owpws_pkg;

   // Width of the phase tick counter
   localparam int unsigned TICK_COUNT_WIDTH = 16;
   // Width of each timing register on the CSR port
   localparam int unsigned CSR_DATA_WIDTH   = 16;
   // CSR index is wide enough to address past the last register
   localparam int unsigned CSR_INDEX_WIDTH  = 3;
   // Pulses in one frame: seven data bits and two trailing zero bits
   localparam int unsigned FRAME_PULSES     = 9;
   localparam int unsigned PULSE_CNT_WIDTH  = 4;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ONE_LOW   = 3'd0,
      CSR_ONE_HIGH  = 3'd1,
      CSR_ZERO_LOW  = 3'd2,
      CSR_ZERO_HIGH = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } req_payload_type;

   typedef struct packed {
      logic pin;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_payload_type;

   typedef logic [TICK_COUNT_WIDTH-1:0] tick_count_type;

   // Keep the low TICK_COUNT_WIDTH bits of a register, zero extend if wider
   function automatic tick_count_type to_ticks(logic [CSR_DATA_WIDTH-1:0] value);
      tick_count_type result;
      result = '0;
      for (int i = 0; i < TICK_COUNT_WIDTH; i++) begin
         if (i < CSR_DATA_WIDTH) begin
            result[i] = value[i];
         end
      end
      return result;
   endfunction

endpackage

/* rtl/core/one_wire_pulse_width_serializer.sv */
// One-wire pulse-width serializer top level.
// Result valid the cycle after accept; one per cycle unless the result is held.
// The result sits in an output register; a new transaction is taken whenever that register
// is empty or is being drained in the same cycle, so both sides can stream with no bubble.
// Reset (synchronous, active high): frame state idle, output empty, timing
// registers back to 2 / 20 / 20 / 40 ticks.
module one_wire_pulse_width_serializer (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  owpws_pkg::req_payload_type                req_payload,
   // result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output owpws_pkg::rsp_payload_type                rsp_payload,
   // configuration write port
   input  logic                                      csr_wr_en,
   input  logic [owpws_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [owpws_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);
   import owpws_pkg::*;

   // Timing registers
   logic [CSR_DATA_WIDTH-1:0] one_low_ff,  one_high_ff;
   logic [CSR_DATA_WIDTH-1:0] zero_low_ff, zero_high_ff;

   // Frame state
   logic [FRAME_PULSES-1:0]    shifter_ff,    shifter_in;   // current bit at the top
   logic [PULSE_CNT_WIDTH-1:0] bits_left_ff,  bits_left_in; // pulses left, current included
   logic                       low_phase_ff,  low_phase_in;
   tick_count_type             phase_cnt_ff,  phase_cnt_in; // ticks left in this phase
   logic                       sending_ff,    sending_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   logic req_accept;
   logic done;
   logic rej;
   logic cur_bit;

   // Stall only when a finished result is held and the consumer is not taking it
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Configuration writes; indexes past the last register are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         one_low_ff   <= CSR_DATA_WIDTH'(2);
         one_high_ff  <= CSR_DATA_WIDTH'(20);
         zero_low_ff  <= CSR_DATA_WIDTH'(20);
         zero_high_ff <= CSR_DATA_WIDTH'(40);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ONE_LOW:   one_low_ff   <= csr_wdata;
            CSR_ONE_HIGH:  one_high_ff  <= csr_wdata;
            CSR_ZERO_LOW:  zero_low_ff  <= csr_wdata;
            CSR_ZERO_HIGH: zero_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next frame state for one transaction
   always_comb begin
      shifter_in   = shifter_ff;
      bits_left_in = bits_left_ff;
      low_phase_in = low_phase_ff;
      phase_cnt_in = phase_cnt_ff;
      sending_in   = sending_ff;
      done         = 1'b0;
      rej          = 1'b0;
      cur_bit      = 1'b0;

      if (req_payload.op == OP_LOAD) begin
         if (sending_ff) begin
            rej = 1'b1;
         end else begin
            // bit 7 falls off; the two low zeros are the trailing pulses
            shifter_in   = {req_payload.data[6:0], 2'b00};
            bits_left_in = PULSE_CNT_WIDTH'(FRAME_PULSES);
            sending_in   = 1'b1;
            low_phase_in = 1'b1;
            cur_bit      = req_payload.data[6];
            phase_cnt_in = to_ticks(cur_bit ? one_low_ff : zero_low_ff);
         end
      end else if (sending_ff) begin
         // A zero count acts like one tick, falling into the phase-end branches
         if (phase_cnt_ff > tick_count_type'(1)) begin
            phase_cnt_in = phase_cnt_ff - tick_count_type'(1);
         end else if (low_phase_ff) begin
            low_phase_in = 1'b0;
            cur_bit      = shifter_ff[FRAME_PULSES-1];
            phase_cnt_in = to_ticks(cur_bit ? one_high_ff : zero_high_ff);
         end else begin
            shifter_in   = {shifter_ff[FRAME_PULSES-2:0], 1'b0};
            bits_left_in = bits_left_ff - PULSE_CNT_WIDTH'(1);
            if (bits_left_ff == PULSE_CNT_WIDTH'(1)) begin
               // end of the last high phase closes the frame
               sending_in   = 1'b0;
               low_phase_in = 1'b0;
               phase_cnt_in = '0;
               done         = 1'b1;
            end else begin
               low_phase_in = 1'b1;
               cur_bit      = shifter_ff[FRAME_PULSES-2];
               phase_cnt_in = to_ticks(cur_bit ? one_low_ff : zero_low_ff);
            end
         end
      end

      rsp_data_in.pin        = ~(sending_in & low_phase_in);
      rsp_data_in.busy_res   = sending_in;
      rsp_data_in.frame_done = done;
      rsp_data_in.rejected   = rej;

      // Output register fills on accept, empties when taken
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         shifter_ff   <= '0;
         bits_left_ff <= '0;
         low_phase_ff <= 1'b0;
         phase_cnt_ff <= '0;
         sending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            shifter_ff   <= shifter_in;
            bits_left_ff <= bits_left_in;
            low_phase_ff <= low_phase_in;
            phase_cnt_ff <= phase_cnt_in;
            sending_ff   <= sending_in;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* bench/tb.sv */
// Self-checking bench for the one-wire pulse-width serializer.
// Streams load/tick transactions, predicts every result from a behavioral frame model and
// checks pin level, busy, frame end and reject flags. Depends on owpws_pkg and the RTL top.
module tb;
   import owpws_pkg::*;

   // ---------------------------------------------------------------- clock, reset, ports
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid   = 1'b0;
   logic                        req_stall;
   req_payload_type             req_payload = '0;

   logic                        rsp_valid;
   logic                        rsp_stall   = 1'b0;
   rsp_payload_type             rsp_payload;

   logic                        csr_wr_en   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata   = '0;

   one_wire_pulse_width_serializer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- bench state
   req_payload_type  tx_items[$];         // transactions still to be sent, front is on the bus
   rsp_payload_type  expected_levels[$];  // predicted results, oldest first
   int               fail_count = 0;
   bit               idling_on  = 1'b1;   // random gaps on both channels
   bit               req_took   = 1'b0;   // request accepted at the last rising edge
   int               send_gap   = 0;
   int               hold_left  = 0;

   // Mirror of the timing registers, reset values 2 / 20 / 20 / 40
   tick_count_type   cfg_one_low   = 16'd2;
   tick_count_type   cfg_one_high  = 16'd20;
   tick_count_type   cfg_zero_low  = 16'd20;
   tick_count_type   cfg_zero_high = 16'd40;

   // Frame state of the predictor
   logic [8:0]                 fr_shift   = '0;  // current bit at the top
   logic [PULSE_CNT_WIDTH-1:0] fr_left    = '0;  // pulses left, current one included
   bit                         fr_low     = 1'b0;
   tick_count_type             fr_count   = '0;  // ticks left in the current phase
   bit                         fr_sending = 1'b0;

   // ---------------------------------------------------------------- predictor
   // Load the phase length for the bit at the top of the shifter.
   task automatic begin_phase(input bit low);
      fr_low   = low;
      if (fr_shift[8])
         fr_count = low ? cfg_one_low : cfg_one_high;
      else
         fr_count = low ? cfg_zero_low : cfg_zero_high;
   endtask

   // One transaction in, one result out; advances the frame state.
   task automatic serialize_step(input req_payload_type t, output rsp_payload_type r);
      bit done;
      bit rej;
      done = 1'b0;
      rej  = 1'b0;
      if (t.op == OP_LOAD) begin
         if (fr_sending) begin
            rej = 1'b1;                   // load while a frame is going: dropped
         end else begin
            fr_shift   = {t.data[6:0], 2'b00};  // bit 7 falls off, two zero pulses trail
            fr_left    = PULSE_CNT_WIDTH'(FRAME_PULSES);
            fr_sending = 1'b1;
            begin_phase(1'b1);
         end
      end else if (fr_sending) begin
         // a phase loaded with zero ends on its first tick, same as one
         if (fr_count > 1) begin
            fr_count = fr_count - 1'b1;
         end else if (fr_low) begin
            begin_phase(1'b0);
         end else begin
            fr_shift = fr_shift << 1;
            fr_left  = fr_left - 1'b1;
            if (fr_left == 0) begin
               fr_sending = 1'b0;
               fr_low     = 1'b0;
               fr_count   = '0;
               done       = 1'b1;
            end else begin
               begin_phase(1'b1);
            end
         end
      end
      r.pin        = !(fr_sending && fr_low);
      r.busy_res   = fr_sending;
      r.frame_done = done;
      r.rejected   = rej;
   endtask

   function automatic int ticks_of(tick_count_type n);
      return (n == 0) ? 1 : int'(n);
   endfunction

   // Ticks a whole pulse (low plus high) takes for one bit value.
   function automatic int bit_ticks(logic b);
      return ticks_of(b ? cfg_one_low : cfg_zero_low) + ticks_of(b ? cfg_one_high : cfg_zero_high);
   endfunction

   function automatic int frame_ticks(logic [7:0] d);
      logic [8:0] s;
      int         n;
      s = {d[6:0], 2'b00};
      n = 0;
      for (int i = 8; i >= 0; i--)
         n += bit_ticks(s[i]);
      return n;
   endfunction

   // ---------------------------------------------------------------- monitor and prediction
   task automatic check_bit(input string name, input logic want, input logic got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 100)
            $error("%s expected %0b actual %0b", name, want, got);
      end
   endtask

   // Outputs and request handshake sampled at the rising edge. The result check runs before
   // the new prediction is queued so the oldest expectation is always the one compared.
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      rsp_payload_type pred;
      if (reset) begin
         req_took   <= 1'b0;
         expected_levels.delete();
         fr_shift   = '0;
         fr_left    = '0;
         fr_low     = 1'b0;
         fr_count   = '0;
         fr_sending = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               fail_count++;
               if (fail_count <= 100)
                  $error("result transaction with none outstanding: %b", rsp_payload);
            end else begin
               want = expected_levels.pop_front();
               check_bit("pin",        want.pin,        rsp_payload.pin);
               check_bit("busy_res",   want.busy_res,   rsp_payload.busy_res);
               check_bit("frame_done", want.frame_done, rsp_payload.frame_done);
               check_bit("rejected",   want.rejected,   rsp_payload.rejected);
            end
         end
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            serialize_step(req_payload, pred);
            expected_levels.push_back(pred);
            void'(tx_items.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- request driver
   // Changes at the falling edge. A transaction on the bus is held until accepted; gaps
   // are only opened between transactions.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (tx_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_payload <= tx_items[0];
         end
      end
   end

   // ---------------------------------------------------------------- result back-pressure
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && !reset && $urandom_range(0, 15) == 0) begin
         hold_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   task automatic queue_item(input op_type op, input logic [7:0] d);
      req_payload_type t;
      t.op   = op;
      t.data = d;
      tx_items.push_back(t);
   endtask

   // Wait until every queued transaction is sent and its result checked.
   task automatic drain();
      while (tx_items.size() != 0 || expected_levels.size() != 0)
         @(negedge clock);
   endtask

   // Register write; the mirror follows at once since nothing is in flight.
   task automatic write_timing(input logic [CSR_INDEX_WIDTH-1:0] idx,
                               input logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ONE_LOW:   cfg_one_low   = tick_count_type'(val);
         CSR_ONE_HIGH:  cfg_one_high  = tick_count_type'(val);
         CSR_ZERO_LOW:  cfg_zero_low  = tick_count_type'(val);
         CSR_ZERO_HIGH: cfg_zero_high = tick_count_type'(val);
         default: ;     // index past the last register: no effect
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Bring the serializer back to idle: send exactly the ticks the running frame still needs.
   task automatic finish_frame();
      int n;
      drain();
      n = 0;
      if (fr_sending) begin
         n = ticks_of(fr_count);
         if (fr_low)
            n += ticks_of(fr_shift[8] ? cfg_one_high : cfg_zero_high);
         for (int j = 1; j < fr_left; j++)
            n += bit_ticks(fr_shift[8 - j]);
      end
      repeat (n) queue_item(OP_TICK, 8'($urandom));
      drain();
   endtask

   // ---------------------------------------------------------------- run sequence
   initial begin : run
      int         n;
      int         k;
      int         pick;
      int         stray;
      logic [7:0] d;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset timing: idle tick, all-ones byte with bit 7 set, load while busy
      queue_item(OP_TICK, 8'hFF);
      queue_item(OP_LOAD, 8'hFF);
      queue_item(OP_LOAD, 8'h00);
      finish_frame();

      // Shortest legal phases; all-zero frame with only bit 7 set, then all data ones
      write_timing(CSR_ONE_LOW,   16'd1);
      write_timing(CSR_ONE_HIGH,  16'd1);
      write_timing(CSR_ZERO_LOW,  16'd1);
      write_timing(CSR_ZERO_HIGH, 16'd1);
      queue_item(OP_LOAD, 8'h80);
      finish_frame();
      queue_item(OP_LOAD, 8'h7F);
      finish_frame();

      // Zero-length phases count as one tick; a write past the last index changes nothing
      write_timing(CSR_ONE_LOW,   16'd0);
      write_timing(CSR_ONE_HIGH,  16'd0);
      write_timing(CSR_ZERO_LOW,  16'd0);
      write_timing(CSR_ZERO_HIGH, 16'd0);
      queue_item(OP_TICK, 8'h00);
      queue_item(OP_LOAD, 8'h55);
      finish_frame();
      write_timing(3'(CSR_ZERO_HIGH) + 3'($urandom_range(1, 4)), 16'($urandom));
      queue_item(OP_LOAD, 8'h2A);
      finish_frame();

      // Random phases with short timing. Mostly whole frames (load then about the right
      // number of ticks), some cut short or padded, stray loads and loose transactions.
      for (int ph = 0; ph < 6; ph++) begin
         idling_on = (ph != 2);
         for (int r = CSR_ONE_LOW; r <= CSR_ZERO_HIGH; r++)
            write_timing(3'(r), ($urandom_range(0, 15) == 0) ? 16'($urandom_range(5, 30))
                                                            : 16'($urandom_range(0, 4)));
         if (ph % 2 == 1)
            write_timing(3'(CSR_ZERO_HIGH) + 3'($urandom_range(1, 4)), 16'($urandom));
         n = 0;
         while (n < 150) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               d     = 8'($urandom);
               k     = frame_ticks(d) + $urandom_range(0, 4) - 2;
               stray = ($urandom_range(0, 4) == 0) ? $urandom_range(0, k - 1) : -1;
               queue_item(OP_LOAD, d);
               for (int i = 0; i < k; i++)
                  queue_item((i == stray) ? OP_LOAD : OP_TICK, 8'($urandom));
               n += k + 1;
            end else if (pick < 9) begin
               k = $urandom_range(1, 4);
               repeat (k) queue_item(OP_TICK, 8'($urandom));
               n += k;
            end else begin
               queue_item(op_type'($urandom_range(0, 1)), 8'($urandom));
               n++;
            end
         end
         // sender waits here for every result before the next register setting
         finish_frame();
      end

      // Final part, no idling: long phases. A single one bit with long phases (zero bits
      // at the zero-length floor), a load rejected deep inside that frame, then long zero
      // phases on the two trailing pulses.
      idling_on = 1'b0;
      write_timing(CSR_ONE_LOW,   16'd48);
      write_timing(CSR_ONE_HIGH,  16'd64);
      write_timing(CSR_ZERO_LOW,  16'd0);
      write_timing(CSR_ZERO_HIGH, 16'd0);
      queue_item(OP_LOAD, 8'h40);
      repeat (60) queue_item(OP_TICK, 8'($urandom));
      queue_item(OP_LOAD, 8'h3F);
      finish_frame();
      write_timing(CSR_ONE_LOW,   16'd1);
      write_timing(CSR_ONE_HIGH,  16'd1);
      write_timing(CSR_ZERO_LOW,  16'd48);
      write_timing(CSR_ZERO_HIGH, 16'd64);
      queue_item(OP_LOAD, 8'hFF);
      finish_frame();

      // Let any stray result show up before the verdict
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("PASS one_wire_pulse_width_serializer");
      else
         $display("FAIL one_wire_pulse_width_serializer");
      $finish;
   end

   // Watchdog: several times the slowest run, even with every transaction fully stalled
   initial begin
      #2_000_000;
      $display("FAIL one_wire_pulse_width_serializer");
      $finish;
   end

endmodule
